### design/sorted_timer_queue_core_macros.svh
// ----------------------------------------------------------------------------
// sorted timer queue assertion macros
// concurrent assertion shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_CORE_MACROS_SVH
`define SORTED_TIMER_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define STQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// shared request codes, field widths and the fire word type
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int REQ_W      = 2;
	localparam int SLOT_W     = 3;
	localparam int PERIOD_W   = 15;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

	// most expiries reported for one tick
	localparam int MAX_FIRE   = 8;
	localparam int FIRE_CNT_W = 4;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} fire_t;

endpackage

### design/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/stq_seq.sv
// ----------------------------------------------------------------------------
// stq_seq
// request sequencer: walks the deadline-ordered list memory one entry a
// cycle to unlink, insert and pop timers, and hands expiries to the output
// ----------------------------------------------------------------------------
module stq_seq
	import stq_pkg::*;
#(
	parameter int NUM_TIMERS  = 8,
	parameter int COUNT_WIDTH = 16,
	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
	localparam int LW = $clog2(NUM_TIMERS + 1),
	localparam int EW = COUNT_WIDTH + AW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    in_req,
	input  logic [SLOT_W-1:0]   in_slot,
	input  logic [PERIOD_W-1:0] in_period,
	output fire_t               fire,
	input  logic                fire_ready,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output logic [EW-1:0]       ram_wdata,
	output logic                ram_re,
	output logic [AW-1:0]       ram_raddr,
	input  logic [EW-1:0]       ram_rdata
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_UNLINK   = 3'd1;
	localparam logic [2:0] ST_INSERT   = 3'd2;
	localparam logic [2:0] ST_TICK_RD  = 3'd3;
	localparam logic [2:0] ST_TICK_CHK = 3'd4;

	localparam logic [1:0] RET_IDLE   = 2'd0;
	localparam logic [1:0] RET_INSERT = 2'd1;
	localparam logic [1:0] RET_TICK   = 2'd2;

	logic [2:0]             state_q;
	logic [1:0]             ret_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [NUM_TIMERS-1:0]  active_q;
	logic [LW-1:0]          len_q;
	logic [AW-1:0]          slot_q;
	logic [COUNT_WIDTH-1:0] nkey_q;
	logic [LW-1:0]          rd_idx_q;
	logic                   rd_vld_s1;
	logic [LW-1:0]          rd_idx_s1;
	logic                   found_q;
	logic [EW-1:0]          carry_q;
	logic [FIRE_CNT_W-1:0]  fire_n_q;
	logic                   pend_q;
	logic [AW-1:0]          pend_slot_q;

	logic [AW-1:0]          e_slot;
	logic [COUNT_WIDTH-1:0] e_dl;
	logic [COUNT_WIDTH-1:0] ediff;
	logic [COUNT_WIDTH-1:0] new_dl;
	logic [EW-1:0]          new_entry;
	logic [LW-1:0]          prev_idx;
	logic                   walking;
	logic                   walk_rd;
	logic                   walk_done;
	logic                   place;
	logic                   head_exp;
	logic                   accept;
	logic                   slot_ok;
	logic [AW-1:0]          slot_in;

	assign e_slot    = ram_rdata[AW-1:0];
	assign e_dl      = ram_rdata[EW-1:AW];
	assign ediff     = e_dl - tick_q;
	assign new_dl    = tick_q + nkey_q;
	assign new_entry = {new_dl, slot_q};
	assign prev_idx  = rd_idx_s1 - LW'(1);

	assign walking   = (state_q == ST_UNLINK) || (state_q == ST_INSERT);
	assign walk_rd   = walking && (rd_idx_q < len_q);
	assign walk_done = (rd_idx_q == len_q) && !rd_vld_s1;

	// new entry goes ahead of the first one that is not earlier
	assign place = !found_q && ($signed(nkey_q) <= $signed(ediff));

	assign head_exp = (len_q != '0) && ediff[COUNT_WIDTH-1] &&
		(fire_n_q < FIRE_CNT_W'(MAX_FIRE));

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign slot_ok  = int'(in_slot) < NUM_TIMERS;
	assign slot_in  = AW'(in_slot);

	assign ram_re    = walk_rd || (state_q == ST_TICK_RD);
	assign ram_raddr = walk_rd ? rd_idx_q[AW-1:0] : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		if (state_q == ST_UNLINK) begin
			// entries behind the removed one move down
			if (rd_vld_s1 && found_q) begin
				ram_we    = 1'b1;
				ram_waddr = prev_idx[AW-1:0];
				ram_wdata = ram_rdata;
			end
		end else if (state_q == ST_INSERT) begin
			priority if (rd_vld_s1 && place) begin
				ram_we    = 1'b1;
				ram_waddr = rd_idx_s1[AW-1:0];
				ram_wdata = new_entry;
			end else if (rd_vld_s1 && found_q) begin
				ram_we    = 1'b1;
				ram_waddr = rd_idx_s1[AW-1:0];
				ram_wdata = carry_q;
			end else if (walk_done) begin
				ram_we    = 1'b1;
				ram_waddr = len_q[AW-1:0];
				ram_wdata = found_q ? carry_q : new_entry;
			end
		end
	end

	always_comb begin
		fire.valid = (state_q == ST_TICK_CHK) && pend_q;
		fire.slot  = SLOT_W'(pend_slot_q);
		fire.last  = !head_exp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= RET_IDLE;
			tick_q      <= '0;
			active_q    <= '0;
			len_q       <= '0;
			slot_q      <= '0;
			nkey_q      <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			found_q     <= 1'b0;
			carry_q     <= '0;
			fire_n_q    <= '0;
			pend_q      <= 1'b0;
			pend_slot_q <= '0;
		end else begin
			rd_vld_s1 <= walk_rd;
			rd_idx_s1 <= rd_idx_q;
			if (walk_rd) begin
				rd_idx_q <= rd_idx_q + LW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					found_q  <= 1'b0;
					if (accept) begin
						slot_q <= slot_in;
						nkey_q <= COUNT_WIDTH'(in_period);
						unique case (in_req)
							REQ_START: begin
								if (slot_ok) begin
									if (active_q[slot_in]) begin
										ret_q   <= RET_INSERT;
										state_q <= ST_UNLINK;
									end else begin
										state_q <= ST_INSERT;
									end
								end
							end
							REQ_CANCEL: begin
								if (slot_ok && active_q[slot_in]) begin
									ret_q   <= RET_IDLE;
									state_q <= ST_UNLINK;
								end
							end
							REQ_TICK: begin
								if (len_q != '0) begin
									tick_q   <= tick_q + COUNT_WIDTH'(1);
									fire_n_q <= '0;
									pend_q   <= 1'b0;
									state_q  <= ST_TICK_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_UNLINK: begin
					if (rd_vld_s1 && !found_q && (e_slot == slot_q)) begin
						found_q <= 1'b1;
					end
					if (walk_done) begin
						len_q            <= len_q - LW'(1);
						active_q[slot_q] <= 1'b0;
						rd_idx_q         <= '0;
						found_q          <= 1'b0;
						unique case (ret_q)
							RET_INSERT: state_q <= ST_INSERT;
							RET_TICK:   state_q <= ST_TICK_RD;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INSERT: begin
					if (rd_vld_s1 && (place || found_q)) begin
						found_q <= 1'b1;
						carry_q <= ram_rdata;
					end
					if (walk_done) begin
						len_q            <= len_q + LW'(1);
						active_q[slot_q] <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				ST_TICK_RD: begin
					state_q <= ST_TICK_CHK;
				end
				ST_TICK_CHK: begin
					// hold the head word until the pending expiry is taken
					if (!pend_q || fire_ready) begin
						if (head_exp) begin
							pend_q      <= 1'b1;
							pend_slot_q <= e_slot;
							fire_n_q    <= fire_n_q + FIRE_CNT_W'(1);
							slot_q      <= e_slot;
							ret_q       <= RET_TICK;
							rd_idx_q    <= '0;
							found_q     <= 1'b0;
							state_q     <= ST_UNLINK;
						end else begin
							pend_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/stq_out_stage.sv
// ----------------------------------------------------------------------------
// stq_out_stage
// output register for expiry words, decouples the sequencer from the sink
// ----------------------------------------------------------------------------
module stq_out_stage
	import stq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  fire_t                 fire,
	output logic                  fire_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	logic              valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic              last_q;

	assign fire_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= '0;
			last_q  <= 1'b0;
		end else if (fire_ready) begin
			valid_q <= fire.valid;
			if (fire.valid) begin
				slot_q <= fire.slot;
				last_q <= fire.last;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_DATA_W'(slot_q);
	assign m_tlast  = last_q;

endmodule

### design/sorted_timer_queue_core.sv
// start: one insert walk, after an unlink walk when the slot was already armed
// cancel: one unlink walk; tick: a head read, plus an unlink walk per expired slot popped
// len is the current list length; the list memory is walked one entry a cycle
// through its single read port, so the list length sets how long each request takes
// first expiry word waits for the head read, an unlink walk and the output register
// reset clears counter, armed flags, list length and output valid at once; no clearing pass
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// one-shot timers sharing a tick counter, kept in a deadline-ordered list
// ----------------------------------------------------------------------------
module sorted_timer_queue_core
	import stq_pkg::*;
#(
	parameter int NUM_TIMERS  = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // slot [2:0], period [17:3]
	input  logic [REQ_W-1:0]      s_tuser,   // req_type [1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // fired_slot [2:0]
	output logic                  m_tlast    // last_fired
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int EW = COUNT_WIDTH + AW;

	fire_t         fire;
	logic          fire_ready;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	// list entry: deadline above, slot number below
	stq_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_TIMERS)
	) u_list_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	stq_seq #(
		.NUM_TIMERS (NUM_TIMERS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser),
		.in_slot   (s_tdata[SLOT_W-1:0]),
		.in_period (s_tdata[SLOT_W+PERIOD_W-1:SLOT_W]),
		.fire      (fire),
		.fire_ready(fire_ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	stq_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.fire_ready(fire_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### design/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// port-level checks on the timer queue, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_core_macros.svh"

module stq_checker
	import stq_pkg::*;
#(
	parameter int NUM_TIMERS = 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [REQ_W-1:0]      s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	logic [FIRE_CNT_W-1:0] nonlast_q;
	logic                  start_ok;

	assign start_ok = s_tvalid && s_tready && (s_tuser == REQ_START) &&
		(int'(s_tdata[SLOT_W-1:0]) < NUM_TIMERS);

	// words of the current tick not yet closed by a last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonlast_q <= '0;
		end else if (m_tvalid && m_tready) begin
			nonlast_q <= m_tlast ? '0 : nonlast_q + FIRE_CNT_W'(1);
		end
	end

	`STQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
	`STQ_ASSERT_NEXT(a_start_busy, start_ok, !s_tready, "start request did not walk the list")
	`STQ_ASSERT_NOW(a_fire_limit, m_tvalid && m_tready && !m_tlast, nonlast_q < FIRE_CNT_W'(MAX_FIRE - 1), "too many expiries in one tick")
	`STQ_ASSERT_NOW(a_fire_busy, $rose(m_tvalid), $past(!s_tready), "expiry word without a busy tick")

endmodule

bind sorted_timer_queue_core stq_checker #(
	.NUM_TIMERS(NUM_TIMERS)
) u_stq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
